>>> rtl/lsab_pkg.sv
package lsab_pkg;

  // field widths
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CNT_W      = 32;
  // burst sum: 16 samples of 4095 still fit in 16 bits
  localparam int unsigned SUM_W      = 16;

  // defaults for the top level parameters
  localparam int unsigned SAMPLES_DEF     = 10;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_ENABLE    = 2'd0,
    CFG_MANUAL_PERCENT = 2'd1
  } cfg_idx_e;

  // arithmetic constants
  localparam logic [PCT_W-1:0]    MANUAL_RESET = 7'd100;
  localparam logic [PCT_W-1:0]    PCT_FULL     = 7'd100;
  localparam logic [PCT_W-1:0]    TARGET_BASE  = 7'd20;
  localparam logic [SAMPLE_W-1:0] CLAMP_LEVEL  = 12'd4000;
  localparam logic [SAMPLE_W-1:0] MIN_RESET    = 12'hFFF;
  // x / 5 as (x * 205) >> 10, exact for x below 1024
  localparam int unsigned         DIV5_MUL     = 205;
  localparam int unsigned         DIV5_SHIFT   = 10;
  // x * 4 / 5 as (x * 820) >> 10
  localparam int unsigned         MUL4DIV5_MUL = 820;

  // request from front to back
  typedef struct packed {
    logic             timeout;
    logic [SUM_W-1:0] trimmed;
  } req_t;

  // configuration seen by the back end
  typedef struct packed {
    logic             auto_en;
    logic [PCT_W-1:0] manual;
  } cfg_t;

endpackage

>>> rtl/lsab_chan_if.sv
interface lsab_in_if;
  logic                          valid;
  logic                          ready;
  logic [lsab_pkg::SAMPLE_W-1:0] sample;
  logic                          timed_out;

  modport source (output valid, output sample, output timed_out, input ready);
  modport sink   (input valid, input sample, input timed_out, output ready);
endinterface

interface lsab_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [lsab_pkg::SAMPLE_W-1:0] raw_average;
  logic [lsab_pkg::SAMPLE_W-1:0] filtered_level;
  logic [lsab_pkg::PCT_W-1:0]    intensity_pct;
  logic [lsab_pkg::PCT_W-1:0]    backlight_target;
  logic [lsab_pkg::CNT_W-1:0]    bursts_done;
  logic [lsab_pkg::CNT_W-1:0]    error_count;

  modport source (
    output valid, output status, output raw_average, output filtered_level,
    output intensity_pct, output backlight_target, output bursts_done,
    output error_count, input ready
  );
  modport sink (
    input valid, input status, input raw_average, input filtered_level,
    input intensity_pct, input backlight_target, input bursts_done,
    input error_count, output ready
  );
endinterface

>>> rtl/lsab_front.sv
module lsab_front #(
  parameter int unsigned SAMPLES = lsab_pkg::SAMPLES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lsab_in_if.sink        in_chan,
  input  logic           q_full_i,
  output logic           push_o,
  output lsab_pkg::req_t req_o
);

  localparam int unsigned POS_W = $clog2(SAMPLES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SAMPLES - 1);

  logic [lsab_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [lsab_pkg::SAMPLE_W-1:0] min_q, min_d;
  logic [lsab_pkg::SAMPLE_W-1:0] max_q, max_d;
  logic [POS_W-1:0]              pos_q, pos_d;

  logic                          accept;
  logic                          last;
  logic [lsab_pkg::SUM_W-1:0]    sum_nxt;
  logic [lsab_pkg::SAMPLE_W-1:0] min_nxt;
  logic [lsab_pkg::SAMPLE_W-1:0] max_nxt;
  logic [lsab_pkg::SAMPLE_W:0]   extremes;
  logic [lsab_pkg::SUM_W-1:0]    extremes_ext;
  logic [lsab_pkg::SUM_W-1:0]    trimmed;

  // a request is taken whenever the queue has room
  assign in_chan.ready = !q_full_i;
  assign accept        = in_chan.valid && in_chan.ready;
  assign last          = (pos_q == LAST_POS);

  // running sum, minimum and maximum including this sample
  assign sum_nxt = sum_q + lsab_pkg::SUM_W'(in_chan.sample);
  assign min_nxt = (in_chan.sample < min_q) ? in_chan.sample : min_q;
  assign max_nxt = (in_chan.sample > max_q) ? in_chan.sample : max_q;

  // burst sum without its extremes, floored at zero
  assign extremes     = {1'b0, min_nxt} + {1'b0, max_nxt};
  assign extremes_ext = lsab_pkg::SUM_W'(extremes);
  assign trimmed      = (sum_nxt < extremes_ext) ? '0 : (sum_nxt - extremes_ext);

  // hand a finished or aborted burst to the back end
  assign push_o        = accept && (in_chan.timed_out || last);
  assign req_o.timeout = in_chan.timed_out;
  assign req_o.trimmed = in_chan.timed_out ? '0 : trimmed;

  // burst accumulator next state
  always_comb begin
    sum_d = sum_q;
    min_d = min_q;
    max_d = max_q;
    pos_d = pos_q;
    if (accept) begin
      if (in_chan.timed_out || last) begin
        sum_d = '0;
        min_d = lsab_pkg::MIN_RESET;
        max_d = '0;
        pos_d = '0;
      end else begin
        sum_d = sum_nxt;
        min_d = min_nxt;
        max_d = max_nxt;
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // burst accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      min_q <= lsab_pkg::MIN_RESET;
      max_q <= '0;
      pos_q <= '0;
    end else begin
      sum_q <= sum_d;
      min_q <= min_d;
      max_q <= max_d;
      pos_q <= pos_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS)
    else $error("burst position beyond last sample");

  a_push_restarts_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (pos_q == '0) && (sum_q == '0))
    else $error("burst not restarted after request");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_i |-> !push_o)
    else $error("request pushed into full queue");
`endif

endmodule

>>> rtl/lsab_queue.sv
module lsab_queue #(
  parameter int unsigned DEPTH = lsab_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lsab_pkg::req_t data_i,
  input  logic           pop_i,
  output lsab_pkg::req_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  lsab_pkg::req_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("fill count missed a push");

  a_count_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
    else $error("fill count missed a pop");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("fill count beyond depth");
`endif

endmodule

>>> rtl/lsab_back.sv
module lsab_back #(
  parameter int unsigned SAMPLES = lsab_pkg::SAMPLES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lsab_pkg::cfg_t cfg_i,
  input  lsab_pkg::req_t head_i,
  input  logic           q_empty_i,
  output logic           pop_o,
  lsab_out_if.source     out_chan
);

  localparam int unsigned SUM_W  = lsab_pkg::SUM_W;
  localparam int unsigned SMP_W  = lsab_pkg::SAMPLE_W;
  localparam int unsigned PCT_W  = lsab_pkg::PCT_W;
  localparam int unsigned CNT_W  = lsab_pkg::CNT_W;
  localparam int unsigned DIV    = SAMPLES - 2;
  // reciprocal of the divisor, scaled so the estimate is low by at most one
  localparam int unsigned RS     = SUM_W;
  localparam int unsigned MW     = RS + 1;
  localparam int unsigned PROD_W = SUM_W + MW;
  localparam logic [MW-1:0]    RECIP = MW'((2 ** RS) / DIV);
  localparam logic [SUM_W-1:0] DIV_C = SUM_W'(DIV);
  localparam int unsigned SM_W   = SMP_W + 2;
  localparam int unsigned EIGHTH_W = SMP_W - 3;
  localparam int unsigned D5_W   = 17;

  logic adv;

  // stage 1: reciprocal product
  logic              s1_valid_q;
  lsab_pkg::req_t    s1_req_q;
  logic [PROD_W-1:0] s1_prod_q;

  // stage 2: corrected quotient, filter and counters
  logic [SUM_W-1:0] q_est;
  logic [SUM_W-1:0] q_times_div;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] q_fixed;
  logic [SMP_W-1:0] raw;
  logic [SM_W-1:0]  smooth_sum;
  logic [SMP_W-1:0] smooth_q, smooth_d;
  logic [CNT_W-1:0] bursts_q, bursts_d;
  logic [CNT_W-1:0] errors_q, errors_d;

  logic             s2_valid_q;
  logic             s2_status_q;
  logic [SMP_W-1:0] s2_raw_q;
  logic [SMP_W-1:0] s2_filt_q;
  logic [CNT_W-1:0] s2_bursts_q;
  logic [CNT_W-1:0] s2_errors_q;

  // stage 3: intensity
  logic [SMP_W-1:0]    clamped;
  logic [EIGHTH_W-1:0] eighth;
  logic [D5_W-1:0]     fortieth_prod;
  logic [PCT_W-1:0]    fortieth;
  logic [PCT_W-1:0]    int_new;
  logic [PCT_W-1:0]    intensity_q, intensity_d;

  logic             s3_valid_q;
  logic             s3_status_q;
  logic [SMP_W-1:0] s3_raw_q;
  logic [SMP_W-1:0] s3_filt_q;
  logic [PCT_W-1:0] s3_int_q;
  logic [CNT_W-1:0] s3_bursts_q;
  logic [CNT_W-1:0] s3_errors_q;

  // output stage: target choice
  logic [D5_W-1:0]  scaled_prod;
  logic [PCT_W-1:0] target_auto;
  logic [PCT_W-1:0] target_manual;
  logic [PCT_W-1:0] target;

  logic             out_valid_q;
  logic             out_status_q;
  logic [SMP_W-1:0] out_raw_q;
  logic [SMP_W-1:0] out_filt_q;
  logic [PCT_W-1:0] out_int_q;
  logic [PCT_W-1:0] out_target_q;
  logic [CNT_W-1:0] out_bursts_q;
  logic [CNT_W-1:0] out_errors_q;

  // whole pipeline moves unless the output register is held
  assign adv   = !out_valid_q || out_chan.ready;
  assign pop_o = adv && !q_empty_i;

  // divide by the trimmed count: estimate, then one correction step
  assign q_est       = s1_prod_q[RS +: SUM_W];
  assign q_times_div = SUM_W'(q_est * DIV_C);
  assign rem         = s1_req_q.trimmed - q_times_div;
  assign q_fixed     = (rem >= DIV_C) ? q_est + 1'b1 : q_est;
  assign raw         = s1_req_q.timeout ? '0 : q_fixed[SMP_W-1:0];

  // smoothing with a quarter weight on the new value
  assign smooth_sum = (SM_W'(smooth_q) << 1) + SM_W'(smooth_q) + SM_W'(raw) + SM_W'(2);

  always_comb begin
    smooth_d = smooth_q;
    bursts_d = bursts_q;
    errors_d = errors_q;
    if (s1_valid_q) begin
      if (s1_req_q.timeout) begin
        errors_d = errors_q + 1'b1;
      end else begin
        smooth_d = (bursts_q == '0) ? raw : smooth_sum[SM_W-1:2];
        bursts_d = bursts_q + 1'b1;
      end
    end
  end

  // intensity from the clamped level over forty
  assign clamped       = (s2_filt_q > lsab_pkg::CLAMP_LEVEL) ? lsab_pkg::CLAMP_LEVEL
                                                               : s2_filt_q;
  assign eighth        = clamped[SMP_W-1:3];
  assign fortieth_prod = D5_W'(eighth) * D5_W'(lsab_pkg::DIV5_MUL);
  assign fortieth      = PCT_W'(fortieth_prod >> lsab_pkg::DIV5_SHIFT);
  assign int_new       = lsab_pkg::PCT_FULL - fortieth;

  always_comb begin
    intensity_d = intensity_q;
    if (s2_valid_q && !s2_status_q) begin
      intensity_d = int_new;
    end
  end

  // backlight target, automatic or saturated manual
  assign scaled_prod   = D5_W'(s3_int_q) * D5_W'(lsab_pkg::MUL4DIV5_MUL);
  assign target_auto   = lsab_pkg::TARGET_BASE + PCT_W'(scaled_prod >> lsab_pkg::DIV5_SHIFT);
  assign target_manual = (cfg_i.manual > lsab_pkg::PCT_FULL) ? lsab_pkg::PCT_FULL
                                                             : cfg_i.manual;
  assign target        = cfg_i.auto_en ? target_auto : target_manual;

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      smooth_q    <= '0;
      bursts_q    <= '0;
      errors_q    <= '0;
      intensity_q <= '0;
    end else if (adv) begin
      s1_valid_q  <= !q_empty_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
      smooth_q    <= smooth_d;
      bursts_q    <= bursts_d;
      errors_q    <= errors_d;
      intensity_q <= intensity_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_req_q     <= head_i;
      s1_prod_q    <= PROD_W'(head_i.trimmed) * PROD_W'(RECIP);
      s2_status_q  <= s1_req_q.timeout;
      s2_raw_q     <= raw;
      s2_filt_q    <= smooth_d;
      s2_bursts_q  <= bursts_d;
      s2_errors_q  <= errors_d;
      s3_status_q  <= s2_status_q;
      s3_raw_q     <= s2_raw_q;
      s3_filt_q    <= s2_filt_q;
      s3_int_q     <= intensity_d;
      s3_bursts_q  <= s2_bursts_q;
      s3_errors_q  <= s2_errors_q;
      out_status_q <= s3_status_q;
      out_raw_q    <= s3_raw_q;
      out_filt_q   <= s3_filt_q;
      out_int_q    <= s3_int_q;
      out_target_q <= target;
      out_bursts_q <= s3_bursts_q;
      out_errors_q <= s3_errors_q;
    end
  end

  assign out_chan.valid             = out_valid_q;
  assign out_chan.status            = out_status_q;
  assign out_chan.raw_average       = out_raw_q;
  assign out_chan.filtered_level    = out_filt_q;
  assign out_chan.intensity_pct     = out_int_q;
  assign out_chan.backlight_target  = out_target_q;
  assign out_chan.bursts_done       = out_bursts_q;
  assign out_chan.error_count       = out_errors_q;

`ifndef SYNTHESIS
  a_stall_freezes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_chan.ready) |=> $stable(smooth_q) && $stable(bursts_q)
                                         && $stable(errors_q))
    else $error("filter state moved while output held");

  a_burst_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q && !s1_req_q.timeout) |=> bursts_q == $past(bursts_q) + 1'b1)
    else $error("burst count not advanced on completed burst");

  a_abort_zero_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_status_q) |-> s2_raw_q == '0)
    else $error("aborted burst carries a raw average");

  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_req_q.timeout) |-> rem < (DIV_C << 1))
    else $error("quotient estimate off by more than one");
`endif

endmodule

>>> rtl/light_sensor_auto_brightness.sv
// Light sensor auto brightness.
// in_chan carries one ADC conversion per request: a 12-bit sample and a
// timeout flag. Samples are grouped into bursts of SAMPLES; the last sample
// of a burst, or any timed-out conversion, yields one request on out_chan,
// all other samples yield none.
// Throughput: one sample per cycle, sustained while out_chan is ready; the
// front accumulator and the four-stage back pipeline each handle one request
// a cycle. The accepting edge of the closing sample writes the queue; the
// request then passes the reciprocal product, quotient fix and filter,
// intensity, and target selection into the out_chan output register.
// A stalled receiver freezes the back pipeline; finished bursts then collect
// in the QUEUE_DEPTH queue, and in_chan.ready drops only when it is full.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i,
// index 0 auto enable and index 1 manual percent, while the block is idle:
// the user must keep to that, since the block itself does not enforce it.
// Reset empties queue and pipeline, clears the burst, filter and counters,
// turns automatic mode off and sets the manual percent to 100.
module light_sensor_auto_brightness #(
  parameter int unsigned SAMPLES     = lsab_pkg::SAMPLES_DEF,
  parameter int unsigned QUEUE_DEPTH = lsab_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lsab_in_if.sink                           in_chan,
  lsab_out_if.source                        out_chan,
  input  logic                              cfg_we_i,
  input  logic [lsab_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lsab_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  logic           auto_q;
  logic [lsab_pkg::PCT_W-1:0] manual_q;
  lsab_pkg::cfg_t cfg;
  lsab_pkg::req_t push_req;
  lsab_pkg::req_t head_req;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q   <= 1'b0;
      manual_q <= lsab_pkg::MANUAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsab_pkg::CFG_AUTO_ENABLE:    auto_q   <= cfg_wdata_i[0];
        lsab_pkg::CFG_MANUAL_PERCENT: manual_q <= cfg_wdata_i[lsab_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.auto_en = auto_q;
  assign cfg.manual  = manual_q;

  // burst accumulation
  lsab_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .q_full_i (q_full),
    .push_o   (push),
    .req_o    (push_req)
  );

  // request queue between front and back
  lsab_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_req),
    .pop_i   (pop),
    .head_o  (head_req),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // averaging, smoothing and target pipeline
  lsab_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .head_i    (head_req),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .out_chan  (out_chan)
  );

endmodule

>>> tb/light_sensor_auto_brightness_tb.sv
module light_sensor_auto_brightness_tb;
  import lsab_pkg::*;

  localparam int unsigned SAMPLES      = SAMPLES_DEF;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned PHASE_ITEMS  = 150;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef enum int {LIGHT_MIXED, LIGHT_BRIGHT, LIGHT_DARK} scene_e;

  typedef struct packed {
    logic                timed_out;
    logic [SAMPLE_W-1:0] sample;
  } adc_conv_t;

  typedef struct packed {
    logic                status;
    logic [SAMPLE_W-1:0] raw_average;
    logic [SAMPLE_W-1:0] filtered_level;
    logic [PCT_W-1:0]    intensity_pct;
    logic [PCT_W-1:0]    backlight_target;
    logic [CNT_W-1:0]    bursts_done;
    logic [CNT_W-1:0]    error_count;
  } brightness_report_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  lsab_in_if  in_chan ();
  lsab_out_if out_chan ();

  light_sensor_auto_brightness #(
    .SAMPLES (SAMPLES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // conversions waiting to be sent and reports waiting to arrive
  adc_conv_t          adc_backlog[$];
  brightness_report_t expected_reports[$];

  // shadow of the block state and registers
  logic                auto_on;
  logic [PCT_W-1:0]    manual_pct;
  logic [SUM_W-1:0]    acc_sum;
  logic [SAMPLE_W-1:0] acc_min;
  logic [SAMPLE_W-1:0] acc_max;
  logic [3:0]          acc_pos;
  logic [SAMPLE_W-1:0] smooth_level;
  logic [PCT_W-1:0]    light_pct;
  logic [CNT_W-1:0]    burst_total;
  logic [CNT_W-1:0]    fault_total;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          in_taken       = 1'b0;
  int unsigned send_run       = 8;
  int unsigned send_gap       = 0;
  logic [15:0] ready_pattern  = '0;
  int unsigned ready_bits     = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void clear_burst_acc();
    acc_sum = '0;
    acc_min = MIN_RESET;
    acc_max = '0;
    acc_pos = '0;
  endfunction

  function automatic brightness_report_t make_report(logic status,
                                                     logic [SAMPLE_W-1:0] raw);
    brightness_report_t rep;
    int unsigned        target;
    if (auto_on) begin
      target = TARGET_BASE + (int'(light_pct) * 80) / 100;
    end else begin
      target = (manual_pct > PCT_FULL) ? PCT_FULL : manual_pct;
    end
    rep.status            = status;
    rep.raw_average       = raw;
    rep.filtered_level    = smooth_level;
    rep.intensity_pct     = light_pct;
    rep.backlight_target  = target[PCT_W-1:0];
    rep.bursts_done       = burst_total;
    rep.error_count       = fault_total;
    return rep;
  endfunction

  // trimmed mean, smoothing and target for one conversion; 1 when a report is due
  function automatic bit predict_conversion(input logic [SAMPLE_W-1:0] s,
                                            input logic timed_out,
                                            output brightness_report_t rep);
    int unsigned total;
    int unsigned edges;
    int unsigned raw;
    int unsigned lvl;
    int unsigned clamped;
    rep = '0;
    if (timed_out) begin
      clear_burst_acc();
      fault_total = fault_total + 1;
      rep = make_report(1'b1, '0);
      return 1'b1;
    end
    acc_sum = acc_sum + SUM_W'(s);
    if (s < acc_min) acc_min = s;
    if (s > acc_max) acc_max = s;
    if (acc_pos < SAMPLES - 1) begin
      acc_pos = acc_pos + 1'b1;
      return 1'b0;
    end
    // drop the extremes and divide by what is left
    total = acc_sum;
    edges = int'(acc_min) + int'(acc_max);
    raw   = (total < edges) ? 0 : (total - edges) / (SAMPLES - 2);
    raw   = raw & 32'h0FFF;
    clear_burst_acc();
    if (burst_total == 0) begin
      smooth_level = raw[SAMPLE_W-1:0];
    end else begin
      lvl = (int'(smooth_level) * 3 + raw + 2) / 4;
      smooth_level = lvl[SAMPLE_W-1:0];
    end
    burst_total = burst_total + 1;
    clamped   = (smooth_level > CLAMP_LEVEL) ? CLAMP_LEVEL : smooth_level;
    light_pct = PCT_W'(PCT_FULL - clamped / 40);
    rep = make_report(1'b0, raw[SAMPLE_W-1:0]);
    return 1'b1;
  endfunction

  // sender: bursts of requests with random gaps
  always @(negedge clk_i) begin : sender
    adc_conv_t conv;
    if (!in_chan.valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_chan.valid <= 1'b0;
      end else if (adc_backlog.size() != 0) begin
        conv = adc_backlog.pop_front();
        in_chan.valid     <= 1'b1;
        in_chan.sample    <= conv.sample;
        in_chan.timed_out <= conv.timed_out;
        send_run--;
        if (send_run == 0) begin
          send_run = $urandom_range(1, 32);
          send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // receiver stalls from a shifting 16-bit pattern
  always @(negedge clk_i) begin
    if (ready_bits == 0) begin
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      ready_bits    = 16;
    end
    out_chan.ready <= ready_pattern[0];
    ready_pattern = ready_pattern >> 1;
    ready_bits--;
  end

  // check reports, then predict from accepted requests
  always @(posedge clk_i) begin : monitor
    brightness_report_t got;
    brightness_report_t want;
    brightness_report_t rep;
    if (rst_ni) begin
      if (out_chan.valid && out_chan.ready) begin
        got.status            = out_chan.status;
        got.raw_average       = out_chan.raw_average;
        got.filtered_level    = out_chan.filtered_level;
        got.intensity_pct     = out_chan.intensity_pct;
        got.backlight_target  = out_chan.backlight_target;
        got.bursts_done       = out_chan.bursts_done;
        got.error_count       = out_chan.error_count;
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected report: st=%0d raw=%0d flt=%0d int=%0d tgt=%0d b=%0d e=%0d",
                     got.status, got.raw_average, got.filtered_level,
                     got.intensity_pct, got.backlight_target,
                     got.bursts_done, got.error_count);
        end else begin
          want = expected_reports.pop_front();
          if (got.status !== want.status || got.raw_average !== want.raw_average ||
              got.filtered_level !== want.filtered_level ||
              got.intensity_pct !== want.intensity_pct ||
              got.backlight_target !== want.backlight_target ||
              got.bursts_done !== want.bursts_done ||
              got.error_count !== want.error_count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch exp: st=%0d raw=%0d flt=%0d int=%0d tgt=%0d b=%0d e=%0d",
                       want.status, want.raw_average, want.filtered_level,
                       want.intensity_pct, want.backlight_target,
                       want.bursts_done, want.error_count);
              $display("         got: st=%0d raw=%0d flt=%0d int=%0d tgt=%0d b=%0d e=%0d",
                       got.status, got.raw_average, got.filtered_level,
                       got.intensity_pct, got.backlight_target,
                       got.bursts_done, got.error_count);
            end
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        in_taken = 1'b1;
        if (predict_conversion(in_chan.sample, in_chan.timed_out, rep))
          expected_reports.push_back(rep);
      end
    end
  end

  function automatic void queue_conv(logic [SAMPLE_W-1:0] s, logic timed_out);
    adc_conv_t conv;
    conv.sample    = s;
    conv.timed_out = timed_out;
    adc_backlog.push_back(conv);
  endfunction

  function automatic logic [SAMPLE_W-1:0] scene_sample(scene_e scene, int style,
                                                       int centre);
    int v;
    case (scene)
      LIGHT_BRIGHT: v = $urandom_range(4000, 4095);
      LIGHT_DARK:   v = $urandom_range(0, 120);
      default: begin
        case (style)
          0: v = $urandom_range(0, 4095);
          1: v = centre + int'($urandom_range(0, 64)) - 32;
          default: v = $urandom_range(0, 1) ? 4095 : 0;
        endcase
      end
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // mostly whole bursts, some lone timeouts and aborted bursts
  function automatic void queue_scene(int unsigned n, scene_e scene);
    int unsigned count;
    int unsigned kind;
    int unsigned len;
    int          style;
    int          centre;
    count = 0;
    while (count < n) begin
      kind   = $urandom_range(0, 11);
      style  = $urandom_range(0, 2);
      centre = $urandom_range(0, 4095);
      if (kind == 0) begin
        queue_conv(12'($urandom), 1'b1);
        count++;
      end else begin
        len = (kind == 1) ? $urandom_range(1, SAMPLES - 1) : SAMPLES;
        for (int unsigned k = 0; k < len; k++)
          queue_conv(scene_sample(scene, style, centre), 1'b0);
        count += len;
        if (kind == 1) begin
          queue_conv(12'($urandom), 1'b1);
          count++;
        end
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx == CFG_AUTO_ENABLE) auto_on = data[0];
    else if (idx == CFG_MANUAL_PERCENT) manual_pct = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (adc_backlog.size() != 0 || in_chan.valid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    in_chan.valid     = 1'b0;
    in_chan.sample    = '0;
    in_chan.timed_out = 1'b0;
    out_chan.ready    = 1'b0;
    auto_on      = 1'b0;
    manual_pct   = MANUAL_RESET;
    smooth_level = '0;
    light_pct    = '0;
    burst_total  = '0;
    fault_total  = '0;
    clear_burst_acc();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // dark burst loads the filter, lone timeout, aborted burst,
    // then a full-scale burst whose single zero is trimmed away
    for (int k = 0; k < SAMPLES; k++) queue_conv(12'd0, 1'b0);
    queue_conv(12'hFFF, 1'b1);
    queue_conv(12'hFFF, 1'b0);
    queue_conv(12'd0, 1'b0);
    queue_conv(12'd2048, 1'b0);
    queue_conv(12'd1, 1'b0);
    queue_conv(12'd0, 1'b1);
    for (int k = 0; k < SAMPLES - 1; k++) queue_conv(12'hFFF, 1'b0);
    queue_conv(12'd0, 1'b0);
    wait_idle();

    // auto mode under full light drives the target to its floor
    write_reg(CFG_AUTO_ENABLE, 7'd1);
    write_reg(CFG_MANUAL_PERCENT, 7'd100);
    queue_scene(PHASE_ITEMS, LIGHT_BRIGHT);
    wait_idle();

    write_reg(CFG_AUTO_ENABLE, 7'd0);
    write_reg(CFG_MANUAL_PERCENT, 7'd0);
    queue_scene(PHASE_ITEMS, LIGHT_DARK);
    wait_idle();

    write_reg(CFG_AUTO_ENABLE, 7'h7F);
    queue_scene(PHASE_ITEMS, LIGHT_DARK);
    wait_idle();

    // manual above 100 saturates, writes to spare indexes change nothing
    write_reg(CFG_AUTO_ENABLE, 7'h7E);
    write_reg(CFG_MANUAL_PERCENT, 7'd127);
    write_reg(CFG_IDX_SPARE_A, 7'h01);
    write_reg(CFG_IDX_SPARE_B, 7'h05);
    queue_scene(PHASE_ITEMS, LIGHT_MIXED);
    wait_idle();

    write_reg(CFG_MANUAL_PERCENT, 7'd101);
    queue_scene(PHASE_ITEMS, LIGHT_MIXED);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_AUTO_ENABLE, 7'($urandom_range(0, 127)));
      write_reg(CFG_MANUAL_PERCENT, 7'($urandom_range(0, 127)));
      write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                7'($urandom_range(0, 127)));
      queue_scene(PHASE_ITEMS, scene_e'($urandom_range(0, 2)));
      wait_idle();
    end

    if (expected_reports.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
